// ----- hdl/tmb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmb_pkg - shared types and constants for the track meter ballistics block
// Level format, phase codes, configuration register indexes and lane control.
// ----------------------------------------------------------------------------
package tmb_pkg;

	localparam int LEVEL_W = 17;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 17'h10000;

	typedef logic [LEVEL_W-1:0] level_t;

	// Meter phase; code 3 is never produced and behaves as playing
	typedef enum logic [1:0] {
		PH_PLAYING  = 2'd0,
		PH_RESUMING = 2'd1,
		PH_PAUSED   = 2'd2
	} phase_t;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VISIBLE_FLOOR = 1'b0,
		CFG_RESUME_WINDOW = 1'b1
	} cfg_reg_t;

	// Control shared by both lanes for one transaction
	typedef struct packed {
		logic   paused;
		logic   el_nz;
		level_t floor_lvl;
	} lane_ctrl_t;

	// Approach amounts for a rising and a falling side
	typedef struct packed {
		level_t amt_up;
		level_t amt_dn;
	} lane_amt_t;

	function automatic level_t sat_level(input level_t v);
		return (v > LEVEL_FULL) ? LEVEL_FULL : v;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/tmb_coef_rom.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmb_coef_rom - approach amount table for one time constant
// Table of 65536 * (1 - exp(-e / TIME_MS)) per elapsed millisecond, with a
// registered read.
// ----------------------------------------------------------------------------
module tmb_coef_rom
	import tmb_pkg::*;
#(
	parameter int TIME_MS = 15
) (
	input  wire logic       clk,
	input  wire logic       en,
	input  wire logic [7:0] el,
	output level_t          amt_s1
);

	localparam logic [63:0] TC = 64'(TIME_MS);

	// exp(-1/TIME_MS) in Q32 by truncated Taylor terms; terms vanish by k = 13
	function automatic logic [31:0] decay_q32();
		logic [63:0] term;
		logic [63:0] sum;
		term = 64'd1 << 32;
		sum  = term;
		term = term / TC / 64'd1;  sum = (sum < term) ? 64'd0 : sum - term;
		term = term / TC / 64'd2;  sum = sum + term;
		term = term / TC / 64'd3;  sum = (sum < term) ? 64'd0 : sum - term;
		term = term / TC / 64'd4;  sum = sum + term;
		term = term / TC / 64'd5;  sum = (sum < term) ? 64'd0 : sum - term;
		term = term / TC / 64'd6;  sum = sum + term;
		term = term / TC / 64'd7;  sum = (sum < term) ? 64'd0 : sum - term;
		term = term / TC / 64'd8;  sum = sum + term;
		term = term / TC / 64'd9;  sum = (sum < term) ? 64'd0 : sum - term;
		term = term / TC / 64'd10; sum = sum + term;
		term = term / TC / 64'd11; sum = (sum < term) ? 64'd0 : sum - term;
		term = term / TC / 64'd12; sum = sum + term;
		term = term / TC / 64'd13; sum = (sum < term) ? 64'd0 : sum - term;
		term = term / TC / 64'd14; sum = sum + term;
		term = term / TC / 64'd15; sum = (sum < term) ? 64'd0 : sum - term;
		term = term / TC / 64'd16; sum = sum + term;
		if (sum >= (64'd1 << 32)) begin
			sum = (64'd1 << 32) - 64'd1;
		end
		return sum[31:0];
	endfunction

	function automatic logic [255:0][LEVEL_W-1:0] build_table(input logic [31:0] d);
		logic [255:0][LEVEL_W-1:0] tab;
		logic [63:0] r;
		logic [63:0] q;
		r = 64'd1 << 32;
		for (int e = 0; e < 256; e++) begin
			q = (r + 64'd32768) >> 16;
			if (q > 64'(LEVEL_FULL)) begin
				q = 64'(LEVEL_FULL);
			end
			tab[e] = LEVEL_FULL - q[LEVEL_W-1:0];
			r = (r * 64'(d)) >> 32;
		end
		return tab;
	endfunction

	localparam logic [31:0] DECAY = decay_q32();
	localparam logic [255:0][LEVEL_W-1:0] AMT_TABLE = build_table(DECAY);

	always_ff @(posedge clk) begin
		if (en) begin
			amt_s1 <= AMT_TABLE[el];
		end
	end

endmodule
`default_nettype wire

// ----- hdl/tmb_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tmb_lane - one side of a track
// Move the current level toward the target with rounding, then snap near
// zero or near full.
// ----------------------------------------------------------------------------
module tmb_lane
	import tmb_pkg::*;
(
	input  wire level_t     cur,
	input  wire level_t     tgt,
	input  wire lane_amt_t  amt,
	input  wire lane_ctrl_t ctrl,
	output level_t          level_nxt,
	output logic            fill_pending
);

	logic        rise;
	level_t      diff;
	level_t      amt_sel;
	logic [33:0] prod;
	logic [34:0] rnd;
	level_t      delta;
	level_t      moved;
	level_t      gap;

	always_comb begin
		rise    = tgt > cur;
		diff    = rise ? (tgt - cur) : (cur - tgt);
		amt_sel = rise ? amt.amt_up : amt.amt_dn;
		prod    = 34'(diff) * 34'(amt_sel);
		rnd     = 35'(prod) + 35'd32768;
		// delta never exceeds diff, so 17 bits hold it
		delta   = rnd[32:16];
		moved   = rise ? (cur + delta) : (cur - delta);
		gap     = LEVEL_FULL - moved;
	end

	always_comb begin
		level_nxt    = moved;
		fill_pending = 1'b0;
		if (ctrl.paused) begin
			if (ctrl.el_nz && (gap < ctrl.floor_lvl)) begin
				level_nxt = LEVEL_FULL;
			end else begin
				fill_pending = moved < LEVEL_FULL;
			end
		end else if (ctrl.el_nz && (tgt == '0) && (moved < ctrl.floor_lvl)) begin
			level_nxt = '0;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/track_meter_ballistics.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// track_meter_ballistics - stereo meter ballistics for a bank of tracks
// Path: an accepted transaction is held in the update stage registers, then
//   it is loaded into the output register when the update stage advances.
// Throughput: one transaction per cycle unless out_stall holds back a full
//   output register, set by the read-modify-write of the level memory (the
//   update stage forwards its own last result when consecutive transactions
//   hit the same track).
// Reset: asynchronous, clears phase, countdown, flags and per-track valid bits;
//   a track that was never written reads as zero, with no clearing pass.
module track_meter_ballistics
	import tmb_pkg::*;
#(
	parameter int TRACKS     = 16,
	parameter int ATTACK_MS  = 15,
	parameter int RELEASE_MS = 250
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [16:0]          cfg_data,
	// input transactions
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 playing,
	input  wire logic [3:0]           track,
	input  wire logic [16:0]          target_left,
	input  wire logic [16:0]          target_right,
	input  wire logic [7:0]           elapsed_ms,
	// result transactions
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [3:0]                track_out,
	output logic [16:0]               level_left,
	output logic [16:0]               level_right,
	output logic                      tick_done,
	output logic                      animating
);

	// Index width of the level memory and a track width wide enough to
	// compare against TRACKS without wrapping
	localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int EXT_W = ((IDX_W > 4) ? IDX_W : 4) + 1;

	// ------------------------------------------------------------------
	// Configuration registers; writes are always taken
	// ------------------------------------------------------------------
	level_t     visible_floor_q;
	logic [7:0] resume_window_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visible_floor_q <= 17'd131;
			resume_window_q <= 8'd75;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_VISIBLE_FLOOR: visible_floor_q <= cfg_data;
				CFG_RESUME_WINDOW: resume_window_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: the update stage advances whenever the output register
	// is empty or being drained
	// ------------------------------------------------------------------
	logic s1_valid;
	logic s1_adv;
	logic accept;

	assign s1_adv   = !out_valid || !out_stall;
	assign in_stall = s1_valid && !s1_adv;
	assign accept   = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Decode the incoming track
	// ------------------------------------------------------------------
	logic [EXT_W-1:0] track_ext;
	logic [IDX_W-1:0] in_idx;
	logic             in_range;
	logic             in_last;

	assign track_ext = EXT_W'(track);
	assign in_idx    = track_ext[IDX_W-1:0];
	assign in_range  = track_ext < EXT_W'(TRACKS);
	assign in_last   = track_ext == EXT_W'(TRACKS - 1);

	// ------------------------------------------------------------------
	// Meter phase: updated in arrival order at the accept edge
	// ------------------------------------------------------------------
	phase_t     phase_q;
	phase_t     phase_d;
	phase_t     ph_eff;
	logic [7:0] resume_left_q;
	logic [7:0] resume_left_d;
	logic [7:0] left_eff;
	logic [7:0] left_dec;
	logic       resume_fast;

	// next state
	always_comb begin
		ph_eff   = phase_q;
		left_eff = resume_left_q;
		case (phase_q)
			PH_PAUSED: begin
				// first playing transaction after a pause opens the window
				if (playing) begin
					ph_eff   = PH_RESUMING;
					left_eff = resume_window_q;
				end
			end
			default: ;
		endcase
		left_dec      = (left_eff > elapsed_ms) ? (left_eff - elapsed_ms) : 8'd0;
		phase_d       = ph_eff;
		resume_left_d = left_eff;
		if (!playing) begin
			phase_d       = PH_PAUSED;
			resume_left_d = resume_window_q;
		end else if (in_last && (ph_eff == PH_RESUMING)) begin
			// count the window down once per tick
			resume_left_d = left_dec;
			phase_d       = (left_dec == 8'd0) ? PH_PLAYING : PH_RESUMING;
		end
	end

	// outputs: fall fast while the resume window is open
	always_comb begin
		resume_fast = playing && (ph_eff == PH_RESUMING);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_PLAYING;
			resume_left_q <= 8'd0;
		end else if (accept && in_range) begin
			phase_q       <= phase_d;
			resume_left_q <= resume_left_d;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 registers: transaction fields, memory read, table reads
	// ------------------------------------------------------------------
	logic             playing_s1;
	logic [3:0]       track_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             in_range_s1;
	logic             last_s1;
	logic             el_nz_s1;
	logic             fast_s1;
	level_t           tgt_l_s1;
	level_t           tgt_r_s1;
	logic             fwd_s1;
	logic             vld_s1;
	logic [33:0]      rd_s1;
	level_t           atk_s1;
	level_t           rel_s1;

	logic [33:0]      lvl_mem [TRACKS];
	logic [TRACKS-1:0] vld_q;

	logic             wr_en;
	level_t           level_nxt_l;
	level_t           level_nxt_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			playing_s1  <= playing;
			track_s1    <= track;
			idx_s1      <= in_idx;
			in_range_s1 <= in_range;
			last_s1     <= in_last;
			el_nz_s1    <= |elapsed_ms;
			fast_s1     <= resume_fast;
			// while paused both sides head for full
			tgt_l_s1    <= playing ? sat_level(target_left) : LEVEL_FULL;
			tgt_r_s1    <= playing ? sat_level(target_right) : LEVEL_FULL;
			// the result being written this edge is not in the read data yet
			fwd_s1      <= wr_en && (track_s1 == track);
			vld_s1      <= vld_q[in_idx];
		end
	end

	// level memory: left level in the upper half, right in the lower half
	always_ff @(posedge clk) begin
		if (wr_en) begin
			lvl_mem[idx_s1] <= {level_nxt_l, level_nxt_r};
		end
		if (accept) begin
			rd_s1 <= lvl_mem[in_idx];
		end
	end

	tmb_coef_rom #(
		.TIME_MS(ATTACK_MS)
	) u_rom_attack (
		.clk   (clk),
		.en    (accept),
		.el    (elapsed_ms),
		.amt_s1(atk_s1)
	);

	tmb_coef_rom #(
		.TIME_MS(RELEASE_MS)
	) u_rom_release (
		.clk   (clk),
		.en    (accept),
		.el    (elapsed_ms),
		.amt_s1(rel_s1)
	);

	// ------------------------------------------------------------------
	// Stage 1 compute: current levels, one lane per side
	// ------------------------------------------------------------------
	level_t     level_left_q;
	level_t     level_right_q;
	level_t     cur_l;
	level_t     cur_r;
	logic       fill_l;
	logic       fill_r;
	lane_amt_t  lane_amt;
	lane_ctrl_t lane_ctrl;

	always_comb begin
		if (fwd_s1) begin
			cur_l = level_left_q;
			cur_r = level_right_q;
		end else if (vld_s1) begin
			cur_l = rd_s1[33:17];
			cur_r = rd_s1[16:0];
		end else begin
			cur_l = '0;
			cur_r = '0;
		end
		lane_amt.amt_up     = playing_s1 ? atk_s1 : rel_s1;
		lane_amt.amt_dn     = fast_s1 ? atk_s1 : rel_s1;
		lane_ctrl.paused    = !playing_s1;
		lane_ctrl.el_nz     = el_nz_s1;
		lane_ctrl.floor_lvl = visible_floor_q;
	end

	tmb_lane u_lane_left (
		.cur         (cur_l),
		.tgt         (tgt_l_s1),
		.amt         (lane_amt),
		.ctrl        (lane_ctrl),
		.level_nxt   (level_nxt_l),
		.fill_pending(fill_l)
	);

	tmb_lane u_lane_right (
		.cur         (cur_r),
		.tgt         (tgt_r_s1),
		.amt         (lane_amt),
		.ctrl        (lane_ctrl),
		.level_nxt   (level_nxt_r),
		.fill_pending(fill_r)
	);

	// ------------------------------------------------------------------
	// Merge: combine lane results, track the tick-wide animating flag,
	// write back and load the output register
	// ------------------------------------------------------------------
	logic any_anim_q;
	logic anim_new;
	logic s1_move;

	assign s1_move  = s1_valid && s1_adv;
	assign wr_en    = s1_move && in_range_s1;
	assign anim_new = any_anim_q || (!playing_s1 && (fill_l || fill_r));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			any_anim_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[idx_s1] <= 1'b1;
				// clear after the last track of each tick
				any_anim_q    <= last_s1 ? 1'b0 : anim_new;
			end
			if (s1_adv) begin
				out_valid <= s1_valid;
			end
		end
	end

	logic [3:0] track_out_q;
	logic       tick_done_q;
	logic       animating_q;

	always_ff @(posedge clk) begin
		if (s1_move) begin
			track_out_q   <= track_s1;
			// a track outside the bank reports zeros
			level_left_q  <= in_range_s1 ? level_nxt_l : '0;
			level_right_q <= in_range_s1 ? level_nxt_r : '0;
			tick_done_q   <= last_s1;
			animating_q   <= last_s1 && (playing_s1 || anim_new);
		end
	end

	assign track_out   = track_out_q;
	assign level_left  = level_left_q;
	assign level_right = level_right_q;
	assign tick_done   = tick_done_q;
	assign animating   = animating_q;

`ifndef SYNTHESIS
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tick_done |-> track_out == 4'(TRACKS - 1))
		else $error("tick_done on a track other than the last");

	a_anim_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && animating |-> tick_done)
		else $error("animating reported outside the last track");

	a_levels_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level_left <= LEVEL_FULL) && (level_right <= LEVEL_FULL))
		else $error("level above full scale");

	a_stall_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid && out_valid)
		else $error("input stalled with an empty pipeline");
`endif

endmodule
`default_nettype wire
